// ----- hw/rtl/coe_pkg.sv -----
// shared types and constants for the clock offset estimator
package coe_pkg;

    localparam int TIME_W   = 63;
    localparam int OFFSET_W = 64;
    localparam int COUNT_W  = 32;
    localparam int RTT_W    = 32;
    localparam int LIMIT_W  = 24;

    localparam logic [LIMIT_W-1:0] RTT_LIMIT_RESET = 24'd20000;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_MAP    = 2'd1,
        MODE_INVAL  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_RTT   = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    // word handed from the sample stage to the tracking stage
    typedef struct packed {
        t_mode                       mode;
        t_status                     status;
        logic signed [OFFSET_W-1:0]  sample;
        logic [RTT_W-1:0]            rtt;
        logic [TIME_W-1:0]           t_local;
        logic [TIME_W-1:0]           remote;
    } t_smp;

    // result word
    typedef struct packed {
        logic [TIME_W-1:0]           mapped_time;
        logic signed [OFFSET_W-1:0]  offset_now;
        logic [COUNT_W-1:0]          sample_count;
        logic [RTT_W-1:0]            last_round_trip;
        logic                        estimate_valid;
        t_status                     sample_status;
    } t_res;

endpackage

// ----- hw/rtl/coe_sample.sv -----
// sample stage: order check, round-trip check and raw offset of one exchange
module coe_sample (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [coe_pkg::LIMIT_W-1:0]     i_rtt_limit,
    input  coe_pkg::t_mode                  i_mode,
    input  logic [coe_pkg::TIME_W-1:0]      i_t1,
    input  logic [coe_pkg::TIME_W-1:0]      i_t2,
    input  logic [coe_pkg::TIME_W-1:0]      i_t3,
    input  logic [coe_pkg::TIME_W-1:0]      i_t4,
    input  logic [coe_pkg::TIME_W-1:0]      i_remote,
    output coe_pkg::t_smp                   o_smp
);

    logic                  ordered;
    logic [63:0]           d41;
    logic [63:0]           d32;
    logic [63:0]           rtt;
    logic                  rtt_bad;
    logic [63:0]           sum_a;
    logic [63:0]           sum_b;
    logic signed [64:0]    diff;
    logic signed [64:0]    half;
    logic signed [64:0]    half_tz;
    coe_pkg::t_status      status;
    coe_pkg::t_smp         r_smp;
    coe_pkg::t_smp         n_smp;

    always_comb begin
        ordered = (i_t4 >= i_t1) && (i_t3 >= i_t2);
        d41     = {1'b0, i_t4} - {1'b0, i_t1};
        d32     = {1'b0, i_t3} - {1'b0, i_t2};
        rtt     = d41 - d32;
        rtt_bad = rtt > {40'd0, i_rtt_limit};

        sum_a   = {1'b0, i_t1} + {1'b0, i_t4};
        sum_b   = {1'b0, i_t2} + {1'b0, i_t3};
        diff    = $signed({1'b0, sum_a}) - $signed({1'b0, sum_b});
        // halve with truncation toward zero
        half    = diff >>> 1;
        half_tz = half + $signed({64'd0, diff[64] & diff[0]});

        if (i_mode != coe_pkg::MODE_SAMPLE) begin
            status = coe_pkg::ST_NONE;
        end else if (!ordered) begin
            status = coe_pkg::ST_ORDER;
        end else if (rtt_bad) begin
            status = coe_pkg::ST_RTT;
        end else begin
            status = coe_pkg::ST_OK;
        end

        n_smp.mode    = i_mode;
        n_smp.status  = status;
        n_smp.sample  = half_tz[63:0];
        n_smp.rtt     = rtt[31:0];
        n_smp.t_local = i_t4;
        n_smp.remote  = i_remote;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_smp <= n_smp;
        end
    end

    assign o_smp = r_smp;

endmodule

// ----- hw/rtl/coe_track.sv -----
// tracking stage: offset filter, counters, time mapping and result register
module coe_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  coe_pkg::t_smp   i_smp,
    output coe_pkg::t_res   o_res
);

    logic signed [coe_pkg::OFFSET_W-1:0]  r_off;
    logic [coe_pkg::COUNT_W-1:0]          r_cnt;
    logic [coe_pkg::RTT_W-1:0]            r_rtt;
    logic                                 r_est_valid;
    logic signed [coe_pkg::OFFSET_W-1:0]  n_off;
    logic [coe_pkg::COUNT_W-1:0]          n_cnt;
    logic [coe_pkg::RTT_W-1:0]            n_rtt;
    logic                                 n_est_valid;
    coe_pkg::t_res                        r_res;
    coe_pkg::t_res                        n_res;

    logic signed [67:0]  off_x;
    logic signed [67:0]  acc;
    logic signed [67:0]  acc_q;
    logic signed [67:0]  filt;
    logic signed [65:0]  map_sum;
    logic [62:0]         mapped;

    always_comb begin
        // (7*old + sample)/8 truncated toward zero, exact
        off_x = {{4{r_off[63]}}, r_off};
        acc   = (off_x <<< 3) - off_x + {{4{i_smp.sample[63]}}, i_smp.sample};
        acc_q = acc >>> 3;
        filt  = acc_q + $signed({67'd0, acc[67] & (|acc[2:0])});

        map_sum = $signed({3'b000, i_smp.remote}) + $signed({{2{r_off[63]}}, r_off});
        if (!r_est_valid) begin
            mapped = i_smp.t_local;
        end else if (map_sum[65] || (map_sum == 66'sd0)) begin
            mapped = '0;
        end else if (map_sum[64:63] != 2'b00) begin
            mapped = '1;
        end else begin
            mapped = map_sum[62:0];
        end
    end

    always_comb begin
        n_off       = r_off;
        n_cnt       = r_cnt;
        n_rtt       = r_rtt;
        n_est_valid = r_est_valid;
        case (i_smp.mode)
            coe_pkg::MODE_SAMPLE: begin
                if (i_smp.status == coe_pkg::ST_OK) begin
                    n_off       = r_est_valid ? filt[63:0] : i_smp.sample;
                    n_cnt       = r_est_valid ? r_cnt + 32'd1 : 32'd1;
                    n_rtt       = i_smp.rtt;
                    n_est_valid = 1'b1;
                end
            end
            coe_pkg::MODE_INVAL: begin
                n_off       = '0;
                n_cnt       = '0;
                n_rtt       = '0;
                n_est_valid = 1'b0;
            end
            default: begin
            end
        endcase

        n_res.mapped_time     = (i_smp.mode == coe_pkg::MODE_MAP) ? mapped : '0;
        n_res.offset_now      = n_off;
        n_res.sample_count    = n_cnt;
        n_res.last_round_trip = n_rtt;
        n_res.estimate_valid  = n_est_valid;
        n_res.sample_status   = i_smp.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off       <= '0;
            r_cnt       <= '0;
            r_rtt       <= '0;
            r_est_valid <= 1'b0;
        end else if (i_fire) begin
            r_off       <= n_off;
            r_cnt       <= n_cnt;
            r_rtt       <= n_rtt;
            r_est_valid <= n_est_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/clock_offset_estimator_core.sv -----
// top level of the clock offset estimator: handshake, config register, stages
// Takes one word per clock when not stalled and returns one result word per input
// word, in order. A word passes an input register, the sample stage (order and
// round-trip checks, raw offset) and the tracking stage, whose filter, counters and
// result register update together. Throughput is one word per cycle when not
// stalled, set by the offset filter loop in the tracking stage. The rtt limit must
// be written through i_cfg_we only while idle; the core does not enforce this.
module clock_offset_estimator_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [coe_pkg::LIMIT_W-1:0]           i_cfg_wdata,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_mode,
    input  logic [coe_pkg::TIME_W-1:0]            i_t_request_local,
    input  logic [coe_pkg::TIME_W-1:0]            i_t_receive_remote,
    input  logic [coe_pkg::TIME_W-1:0]            i_t_reply_remote,
    input  logic [coe_pkg::TIME_W-1:0]            i_t_reply_local,
    input  logic [coe_pkg::TIME_W-1:0]            i_remote_time,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [coe_pkg::TIME_W-1:0]            o_mapped_time,
    output logic signed [coe_pkg::OFFSET_W-1:0]   o_offset_now,
    output logic [coe_pkg::COUNT_W-1:0]           o_sample_count,
    output logic [coe_pkg::RTT_W-1:0]             o_last_round_trip,
    output logic                                  o_estimate_valid,
    output logic [1:0]                            o_sample_status
);

    logic [coe_pkg::LIMIT_W-1:0]  r_rtt_limit;
    logic                         r_av;
    logic                         r_bv;
    logic                         r_ov;
    coe_pkg::t_mode               r_mode;
    logic [coe_pkg::TIME_W-1:0]   r_t1;
    logic [coe_pkg::TIME_W-1:0]   r_t2;
    logic [coe_pkg::TIME_W-1:0]   r_t3;
    logic [coe_pkg::TIME_W-1:0]   r_t4;
    logic [coe_pkg::TIME_W-1:0]   r_remote;
    logic                         out_rdy;
    logic                         b_rdy;
    logic                         a_rdy;
    coe_pkg::t_smp                smp;
    coe_pkg::t_res                res;

    // each stage moves when empty or when the stage after it moves
    assign out_rdy = !r_ov || !i_stall;
    assign b_rdy   = !r_bv || out_rdy;
    assign a_rdy   = !r_av || b_rdy;
    assign o_stall = !a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rtt_limit <= coe_pkg::RTT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_rtt_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (a_rdy) begin
                r_av <= i_valid;
            end
            if (b_rdy) begin
                r_bv <= r_av;
            end
            if (out_rdy) begin
                r_ov <= r_bv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_valid) begin
            r_mode   <= coe_pkg::t_mode'(i_mode);
            r_t1     <= i_t_request_local;
            r_t2     <= i_t_receive_remote;
            r_t3     <= i_t_reply_remote;
            r_t4     <= i_t_reply_local;
            r_remote <= i_remote_time;
        end
    end

    coe_sample u_sample (
        .i_clk       (i_clk),
        .i_load      (b_rdy && r_av),
        .i_rtt_limit (r_rtt_limit),
        .i_mode      (r_mode),
        .i_t1        (r_t1),
        .i_t2        (r_t2),
        .i_t3        (r_t3),
        .i_t4        (r_t4),
        .i_remote    (r_remote),
        .o_smp       (smp)
    );

    coe_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (out_rdy && r_bv),
        .i_smp   (smp),
        .o_res   (res)
    );

    assign o_valid           = r_ov;
    assign o_mapped_time     = res.mapped_time;
    assign o_offset_now      = res.offset_now;
    assign o_sample_count    = res.sample_count;
    assign o_last_round_trip = res.last_round_trip;
    assign o_estimate_valid  = res.estimate_valid;
    assign o_sample_status   = res.sample_status;

endmodule
